// File: sv/mmrc_pkg.sv
// Package with the transaction types, codes and helpers of the Modbus master reply checker.
package mmrc_pkg;

  // Kinds of input transaction.
  localparam logic [1:0] MODE_REQ    = 2'd0;
  localparam logic [1:0] MODE_BYTE   = 2'd1;
  localparam logic [1:0] MODE_RXFAIL = 2'd2;

  // Supported function codes.
  localparam logic [7:0] FC_READ_COILS    = 8'd1;
  localparam logic [7:0] FC_READ_INPUTS   = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT_RG = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
  localparam logic [7:0] FC_WRITE_REG     = 8'd6;
  localparam logic [7:0] FC_DIAGNOSTIC    = 8'd8;
  localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS    = 8'd16;

  // Diagnostic subfunctions that echo the data word, and the counter range.
  localparam logic [15:0] SUB_RETURN_QUERY = 16'h0000;
  localparam logic [15:0] SUB_CLEAR_CNT    = 16'h000A;
  localparam logic [15:0] SUB_CNT_FIRST    = 16'h000B;
  localparam logic [15:0] SUB_CNT_LAST     = 16'h000F;

  // Coils packed into one reply byte, and the saturation point of the byte index.
  localparam int unsigned COIL_BITS_PER_BYTE = 8;
  localparam int unsigned IDX_W              = 9;
  localparam logic [IDX_W-1:0] IDX_MAX       = '1;

  // Frame status codes.
  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_RX_FAIL   = 4'd1,
    ST_BAD_FC    = 4'd2,
    ST_SLAVE     = 4'd3,
    ST_FC        = 4'd4,
    ST_COUNT     = 4'd5,
    ST_COIL_ADDR = 4'd6,
    ST_COIL_QTY  = 4'd7,
    ST_REG_ADDR  = 4'd8,
    ST_REG_QTY   = 4'd9,
    ST_SUBFN     = 4'd10,
    ST_DIAG      = 4'd11,
    ST_SHORT     = 4'd12
  } status_t;

  // Payload of one input transaction.
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  slave_id;
    logic [7:0]  function_code;
    logic [15:0] ref_addr;
    logic [15:0] ref_count;
    logic [7:0]  rx_byte;
    logic        last;
  } in_item_t;

  // Payload of one result transaction.
  typedef struct packed {
    logic [15:0] data_word;
    logic [1:0]  data_count;
    logic        done_res;
    status_t     status;
  } out_item_t;

  // True for the function codes that the checker understands.
  function automatic logic fc_supported(input logic [7:0] fc);
    return (fc == FC_READ_COILS) || (fc == FC_READ_INPUTS) || (fc == FC_READ_HOLDING) ||
           (fc == FC_READ_INPUT_RG) || (fc == FC_WRITE_COIL) || (fc == FC_WRITE_REG) ||
           (fc == FC_DIAGNOSTIC) || (fc == FC_WRITE_COILS) || (fc == FC_WRITE_REGS);
  endfunction

endpackage

// File: sv/mmrc_if.sv
// Valid/ready channel interfaces for the request/reply input and the result output.
interface mmrc_in_if;
  import mmrc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mmrc_out_if;
  import mmrc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/modbus_master_reply_checker_core.sv
// Modbus master reply checker: compares reply bytes against the stored request descriptor.
//
// One input transaction is taken per clock cycle when ready, and its result (if any) is in
// the output register in the next cycle. The input is ready whenever the output register
// is empty or its result is being taken in the same cycle, so a stalled output holds the
// input only while a result is actually waiting. All checks for a byte are made in one
// pass of logic from the stored request and the byte index, ahead of the output register.
module modbus_master_reply_checker_core (
  input logic         clk,
  input logic         rst_n,
  mmrc_in_if.sink     in_ch,
  mmrc_out_if.source  out_ch
);
  import mmrc_pkg::*;

  // Request and frame state.
  logic [7:0]       req_slave_r, req_slave_nxt;
  logic [7:0]       req_function_r, req_function_nxt;
  logic [15:0]      req_address_r, req_address_nxt;
  logic [15:0]      req_count_r, req_count_nxt;
  logic [IDX_W-1:0] byte_index_r, byte_index_nxt;
  status_t          first_error_r, first_error_nxt;
  logic [7:0]       held_byte_r, held_byte_nxt;
  logic             frame_active_r, frame_active_nxt;

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // Per-transaction working signals.
  logic        acc;
  logic        emit, done;
  status_t     st, err_new;
  logic [15:0] dw;
  logic [1:0]  dc;
  logic [16:0] exp_cnt;
  logic [17:0] needed;
  logic        is_read, is_coil_read, echo_sub, known_sub;
  logic [7:0]  b;
  logic [7:0]  fc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data.rx_byte;
  assign fc          = req_function_r;

  // Expected byte count and needed frame length of the stored request.
  always_comb begin
    is_coil_read = (fc == FC_READ_COILS) || (fc == FC_READ_INPUTS);
    is_read      = (fc <= FC_READ_INPUT_RG);
    if (is_coil_read) begin
      exp_cnt = ({1'b0, req_count_r} + 17'(COIL_BITS_PER_BYTE - 1)) >> $clog2(COIL_BITS_PER_BYTE);
    end else begin
      exp_cnt = {req_count_r, 1'b0};
    end
    if (is_read) begin
      needed = {1'b0, exp_cnt} + 18'd3;
    end else if ((fc == FC_WRITE_COIL) || (fc == FC_WRITE_REG)) begin
      needed = 18'd4;
    end else begin
      needed = 18'd6;
    end
    echo_sub  = (req_address_r == SUB_RETURN_QUERY) || (req_address_r == SUB_CLEAR_CNT);
    known_sub = echo_sub || ((req_address_r >= SUB_CNT_FIRST) && (req_address_r <= SUB_CNT_LAST));
  end

  // Checks and state update for one transaction.
  always_comb begin
    req_slave_nxt    = req_slave_r;
    req_function_nxt = req_function_r;
    req_address_nxt  = req_address_r;
    req_count_nxt    = req_count_r;
    byte_index_nxt   = byte_index_r;
    first_error_nxt  = first_error_r;
    held_byte_nxt    = held_byte_r;
    frame_active_nxt = frame_active_r;
    emit             = 1'b0;
    done             = 1'b0;
    st               = ST_OK;
    err_new          = ST_OK;
    dw               = 16'd0;
    dc               = 2'd0;
    case (in_ch.data.mode)
      MODE_REQ: begin
        req_slave_nxt    = in_ch.data.slave_id;
        req_function_nxt = in_ch.data.function_code;
        req_address_nxt  = in_ch.data.ref_addr;
        req_count_nxt    = in_ch.data.ref_count;
        byte_index_nxt   = '0;
        first_error_nxt  = ST_OK;
        held_byte_nxt    = 8'd0;
        if (fc_supported(in_ch.data.function_code)) begin
          frame_active_nxt = 1'b1;
        end else begin
          frame_active_nxt = 1'b0;
          done             = 1'b1;
          st               = ST_BAD_FC;
        end
      end
      MODE_RXFAIL: begin
        if (frame_active_r) begin
          frame_active_nxt = 1'b0;
          done             = 1'b1;
          st               = ST_RX_FAIL;
        end
      end
      MODE_BYTE: begin
        if (frame_active_r) begin
          // Mismatch found by this byte, earlier checks taking priority.
          if (byte_index_r == 9'd0) begin
            if (b != req_slave_r) err_new = ST_SLAVE;
          end else if (byte_index_r == 9'd1) begin
            if (b != fc) err_new = ST_FC;
          end else if (is_read) begin
            if ((byte_index_r == 9'd2) && ({9'd0, b} != exp_cnt)) err_new = ST_COUNT;
          end else if (fc == FC_DIAGNOSTIC) begin
            if ((byte_index_r == 9'd2) && (b != req_address_r[15:8])) err_new = ST_SUBFN;
            if (byte_index_r == 9'd3) begin
              if (b != req_address_r[7:0]) err_new = ST_SUBFN;
              else if (!known_sub) err_new = ST_DIAG;
            end
            if ((byte_index_r == 9'd4) && echo_sub && (b != req_count_r[15:8])) err_new = ST_DIAG;
            if ((byte_index_r == 9'd5) && echo_sub && (b != req_count_r[7:0])) err_new = ST_DIAG;
          end else begin
            if (((byte_index_r == 9'd2) && (b != req_address_r[15:8])) ||
                ((byte_index_r == 9'd3) && (b != req_address_r[7:0]))) begin
              err_new = ((fc == FC_WRITE_COIL) || (fc == FC_WRITE_COILS)) ? ST_COIL_ADDR
                                                                          : ST_REG_ADDR;
            end
            if (((fc == FC_WRITE_COILS) || (fc == FC_WRITE_REGS)) &&
                (((byte_index_r == 9'd4) && (b != req_count_r[15:8])) ||
                 ((byte_index_r == 9'd5) && (b != req_count_r[7:0])))) begin
              err_new = (fc == FC_WRITE_COILS) ? ST_COIL_QTY : ST_REG_QTY;
            end
          end
          first_error_nxt = (first_error_r == ST_OK) ? err_new : first_error_r;

          // Payload forwarding while the frame is still clean.
          if (is_read && (byte_index_r >= 9'd3) && ({9'd0, byte_index_r} < needed) &&
              (first_error_nxt == ST_OK)) begin
            emit = 1'b1;
            dw   = {8'd0, b};
            dc   = 2'd1;
          end
          if (fc == FC_DIAGNOSTIC) begin
            if (byte_index_r == 9'd4) held_byte_nxt = b;
            if ((byte_index_r == 9'd5) && (first_error_nxt == ST_OK)) begin
              emit = 1'b1;
              dw   = {held_byte_r, b};
              dc   = 2'd2;
            end
          end

          // Saturating byte index and frame end.
          if (byte_index_r != IDX_MAX) byte_index_nxt = byte_index_r + 9'd1;
          if (in_ch.data.last) begin
            done             = 1'b1;
            frame_active_nxt = 1'b0;
            if (first_error_nxt != ST_OK) st = first_error_nxt;
            else if ({9'd0, byte_index_nxt} < needed) st = ST_SHORT;
            else st = ST_OK;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register next value.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (acc) begin
      out_valid_nxt           = emit || done;
      out_data_nxt.data_word  = dw;
      out_data_nxt.data_count = dc;
      out_data_nxt.done_res   = done;
      out_data_nxt.status     = done ? st : ST_OK;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_slave_r    <= 8'd0;
      req_function_r <= 8'd0;
      req_address_r  <= 16'd0;
      req_count_r    <= 16'd0;
      byte_index_r   <= '0;
      first_error_r  <= ST_OK;
      held_byte_r    <= 8'd0;
      frame_active_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        req_slave_r    <= req_slave_nxt;
        req_function_r <= req_function_nxt;
        req_address_r  <= req_address_nxt;
        req_count_r    <= req_count_nxt;
        byte_index_r   <= byte_index_nxt;
        first_error_r  <= first_error_nxt;
        held_byte_r    <= held_byte_nxt;
        frame_active_r <= frame_active_nxt;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // An unsupported function code closes the frame at once with its own status.
  a_bad_fc: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_ch.data.mode == MODE_REQ) && !fc_supported(in_ch.data.function_code)
    |=> !frame_active_r && out_valid_r && out_data_r.done_res && (out_data_r.status == ST_BAD_FC))
    else $error("unsupported function code not reported");

  // A result that does not end the frame carries payload and no status.
  a_payload_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.done_res
    |-> (out_data_r.status == ST_OK) && (out_data_r.data_count != 2'd0))
    else $error("non-final result without payload");

  // An empty payload reads as zero.
  a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.data_count == 2'd0) |-> (out_data_r.data_word == 16'd0))
    else $error("data word set with no payload bytes");

  // The byte index moves only with an accepted transaction.
  a_index_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(byte_index_r))
    else $error("byte index changed without a transaction");

endmodule
